>>> sv/dtw_pkg.sv
// Package: shared types, constants and state codes for the DTW distance core.
package dtw_pkg;

    localparam int MAX_LEN     = 64;
    localparam int MAX_DIMS    = 8;
    localparam int STORE_DEPTH = MAX_LEN * MAX_DIMS;
    localparam int SA_W        = $clog2(STORE_DEPTH);
    localparam int IDX_W       = $clog2(MAX_LEN);
    localparam int DIM_W       = $clog2(MAX_DIMS) + 1;
    localparam int CM_DEPTH    = MAX_LEN * MAX_LEN;
    localparam int CM_W        = $clog2(CM_DEPTH);
    localparam int COST_W      = 48;
    localparam int LEN_W       = 7;
    localparam int CFG_W       = 7;
    localparam int PLEN_W      = IDX_W + 2;

    localparam logic CFG_SEQ_LENGTH = 1'b0;
    localparam logic CFG_NUM_DIMS   = 1'b1;

    typedef struct packed {
        logic [15:0] sample_a;
        logic [15:0] sample_b;
        logic        last_pair;
    } dtw_in_t;

    typedef struct packed {
        logic [31:0]      distance;
        logic [LEN_W-1:0] path_length;
    } dtw_out_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_F_ADDR,
        ST_F_WAIT,
        ST_F_ACC,
        ST_F_RD1,
        ST_F_RD2,
        ST_F_RD3,
        ST_F_WAIT3,
        ST_F_WR,
        ST_B_INIT,
        ST_B_WAITC,
        ST_B_STEP,
        ST_B_RD1,
        ST_B_RD2,
        ST_B_WAIT3,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } dtw_state_t;

endpackage

>>> sv/dtw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dtw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/dtw_path_normalized_distance_core.sv
// Top level: multivariate DTW distance with path-length normalisation.
// After the item flagged last the core fills the cost matrix, backtracks
// the path from the far corner, then multiplies, divides and takes the
// square root before the result strobe.
// Throughput: one item per cycle while loading; busy until after the strobe.
// Reset: asynchronous active low; registers to 64 / 1, load address to 0.
module dtw_path_normalized_distance_core
    import dtw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  dtw_in_t          in_item,
    output logic             done,
    output dtw_out_t         result,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    // configuration
    logic [6:0] seq_length_reg;
    logic [3:0] num_dims_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_length_reg <= 7'd64;
            num_dims_reg   <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEQ_LENGTH: seq_length_reg <= cfg_data;
                CFG_NUM_DIMS:   num_dims_reg   <= cfg_data[3:0];
                default:        seq_length_reg <= seq_length_reg;
            endcase
        end
    end

    // clamped working copies (taken at the final item)
    logic [IDX_W:0]   n_eff;
    logic [DIM_W-1:0] d_eff;
    always_comb
    begin
        if (seq_length_reg == 7'd0)
            n_eff = (IDX_W+1)'(1);
        else if (seq_length_reg > 7'(MAX_LEN))
            n_eff = (IDX_W+1)'(MAX_LEN);
        else
            n_eff = (IDX_W+1)'(seq_length_reg);
        if (num_dims_reg == 4'd0)
            d_eff = DIM_W'(1);
        else if ({1'b0, num_dims_reg} > 5'(MAX_DIMS))
            d_eff = DIM_W'(MAX_DIMS);
        else
            d_eff = DIM_W'(num_dims_reg);
    end

    // sample stores and cost matrix
    logic            accept;
    logic [SA_W-1:0] load_pos_reg;
    logic [SA_W-1:0] sa_raddr, sb_raddr;
    logic [15:0]     sa_rdata, sb_rdata;
    logic            cm_we;
    logic [CM_W-1:0] cm_waddr, cm_raddr;
    logic [COST_W-1:0] cm_wdata, cm_rdata;

    assign accept = start && !busy;

    dtw_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_store_a (
        .clk(clk), .we(accept), .waddr(load_pos_reg), .wdata(in_item.sample_a),
        .raddr(sa_raddr), .rdata(sa_rdata));
    dtw_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_store_b (
        .clk(clk), .we(accept), .waddr(load_pos_reg), .wdata(in_item.sample_b),
        .raddr(sb_raddr), .rdata(sb_rdata));
    dtw_ram #(.WIDTH(COST_W), .DEPTH(CM_DEPTH)) u_cost (
        .clk(clk), .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata),
        .raddr(cm_raddr), .rdata(cm_rdata));

    // datapath registers
    dtw_state_t        state_reg, state_next;
    logic [IDX_W:0]    n_reg;
    logic [DIM_W-1:0]  dims_reg;
    logic [IDX_W-1:0]  i_reg, i_next, j_reg, j_next;
    logic [DIM_W-1:0]  k_reg, k_next;
    logic [SA_W+1:0]   ka_reg, ka_next;        // k*n base, kept below 2*depth
    logic [COST_W-1:0] acc_reg, acc_next;
    logic [COST_W-1:0] up_reg, up_next, left_reg, left_next;
    logic [COST_W-1:0] cost_reg, cost_next;
    logic [PLEN_W-1:0] len_reg, len_next;
    logic [DIM_W+2*PLEN_W-1:0] den_reg, den_next;
    logic [PLEN_W*2-1:0] sq_reg, sq_next;
    logic [COST_W-1:0] q_reg, q_next, rem_reg, rem_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [COST_W-1:0] sv_reg, sv_next;        // square-root remainder work
    logic [COST_W-1:0] root_reg, root_next;
    logic [31:0]       dist_reg, dist_next;
    logic              done_next;

    // sample address: (k*n + idx) mod depth
    logic [SA_W+1:0] a_sum, b_sum;
    always_comb
    begin
        a_sum = ka_reg + (SA_W+2)'(i_reg);
        b_sum = ka_reg + (SA_W+2)'(j_reg);
        if (a_sum >= (SA_W+2)'(STORE_DEPTH)) a_sum = a_sum - (SA_W+2)'(STORE_DEPTH);
        if (b_sum >= (SA_W+2)'(STORE_DEPTH)) b_sum = b_sum - (SA_W+2)'(STORE_DEPTH);
        sa_raddr = a_sum[SA_W-1:0];
        sb_raddr = b_sum[SA_W-1:0];
    end

    // squared difference and saturating accumulate
    logic [16:0]       diff;
    logic [15:0]       adiff;
    logic [31:0]       sqd;
    logic [COST_W:0]   acc_sum;
    assign diff  = {1'b0, sa_rdata} - {1'b0, sb_rdata};
    assign adiff = diff[16] ? 16'(-diff) : diff[15:0];
    assign sqd   = 32'(adiff) * 32'(adiff);
    assign acc_sum = {1'b0, acc_reg} + (COST_W+1)'(sqd);

    function automatic logic [COST_W-1:0] sat48(input logic [COST_W:0] s);
        sat48 = s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
    endfunction

    function automatic logic [CM_W-1:0] cm_at(input logic [IDX_W-1:0] r,
                                              input logic [IDX_W-1:0] c);
        cm_at = {r, c};
    endfunction

    logic [COST_W-1:0] m3;
    logic [COST_W:0]   wsum;
    logic [IDX_W-1:0]  last_idx;
    assign last_idx = IDX_W'(n_reg - (IDX_W+1)'(1));

    // division trial
    logic [COST_W:0]   div_rem;
    assign div_rem = {rem_reg, q_reg[COST_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            load_pos_reg <= '0;
            done         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= done_next;
            if (accept)
            begin
                if (in_item.last_pair)
                    load_pos_reg <= '0;
                else
                    load_pos_reg <= load_pos_reg + SA_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_item.last_pair)
        begin
            n_reg    <= n_eff;
            dims_reg <= d_eff;
        end
        i_reg <= i_next;   j_reg <= j_next;   k_reg <= k_next;
        ka_reg <= ka_next; acc_reg <= acc_next;
        up_reg <= up_next; left_reg <= left_next; cost_reg <= cost_next;
        len_reg <= len_next; den_reg <= den_next; sq_reg <= sq_next;
        q_reg <= q_next; rem_reg <= rem_next; cnt_reg <= cnt_next;
        sv_reg <= sv_next; root_reg <= root_next; dist_reg <= dist_next;
    end

    assign result.distance    = dist_reg;
    assign result.path_length = LEN_W'(len_reg);

    // sequencer: fill, backtrack, multiply, divide, square root, output
    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg; j_next = j_reg; k_next = k_reg; ka_next = ka_reg;
        acc_next = acc_reg; up_next = up_reg; left_next = left_reg;
        cost_next = cost_reg; len_next = len_reg; den_next = den_reg;
        sq_next = sq_reg; q_next = q_reg; rem_next = rem_reg; cnt_next = cnt_reg;
        sv_next = sv_reg; root_next = root_reg; dist_next = dist_reg;
        done_next = 1'b0;
        busy      = (state_reg != ST_IDLE);
        cm_we = 1'b0; cm_waddr = cm_at(i_reg, j_reg); cm_wdata = '0;
        cm_raddr = cm_at(i_reg, j_reg);
        m3 = left_reg;
        if (up_reg < m3) m3 = up_reg;
        if (cm_rdata < m3) m3 = cm_rdata;
        wsum = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_item.last_pair)
                begin
                    i_next = '0; j_next = '0;
                    state_next = ST_F_ADDR;
                end
            end
            ST_F_ADDR:
            begin
                k_next = '0; ka_next = '0; acc_next = '0;
                state_next = ST_F_WAIT;
            end
            ST_F_WAIT:
            begin
                // store read for dimension k issued from ka/i/j
                state_next = ST_F_ACC;
            end
            ST_F_ACC:
            begin
                acc_next = sat48(acc_sum);
                k_next   = k_reg + DIM_W'(1);
                ka_next  = ka_reg + (SA_W+2)'(n_reg);
                if (ka_next >= (SA_W+2)'(STORE_DEPTH))
                    ka_next = ka_next - (SA_W+2)'(STORE_DEPTH);
                if (k_next == dims_reg)
                    state_next = ST_F_RD1;
                else
                    state_next = ST_F_WAIT;
            end
            ST_F_RD1:
            begin
                // fetch up neighbour
                cm_raddr = cm_at(i_reg - IDX_W'(1), j_reg);
                state_next = ST_F_RD2;
            end
            ST_F_RD2:
            begin
                cm_raddr = cm_at(i_reg, j_reg - IDX_W'(1));
                up_next  = cm_rdata;
                state_next = ST_F_RD3;
            end
            ST_F_RD3:
            begin
                cm_raddr  = cm_at(i_reg - IDX_W'(1), j_reg - IDX_W'(1));
                left_next = cm_rdata;
                state_next = ST_F_WAIT3;
            end
            ST_F_WAIT3:
            begin
                // diagonal data is on cm_rdata; pick predecessor
                if (i_reg == '0 && j_reg == '0)
                    cost_next = '0;
                else if (i_reg == '0)
                    cost_next = left_reg;
                else if (j_reg == '0)
                    cost_next = up_reg;
                else
                    cost_next = m3;
                state_next = ST_F_WR;
            end
            ST_F_WR:
            begin
                wsum     = {1'b0, acc_reg} + {1'b0, cost_reg};
                cm_we    = 1'b1;
                cm_wdata = sat48(wsum);
                if (j_reg == last_idx)
                begin
                    j_next = '0;
                    if (i_reg == last_idx)
                    begin
                        cost_next  = sat48(wsum);
                        state_next = ST_B_INIT;
                    end
                    else
                    begin
                        i_next = i_reg + IDX_W'(1);
                        state_next = ST_F_ADDR;
                    end
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                    state_next = ST_F_ADDR;
                end
            end
            ST_B_INIT:
            begin
                i_next = last_idx; j_next = last_idx;
                len_next = PLEN_W'(1);
                state_next = ST_B_STEP;
            end
            ST_B_STEP:
            begin
                if (i_reg == '0 && j_reg == '0)
                    state_next = ST_MUL1;
                else if (i_reg == '0)
                begin
                    j_next = j_reg - IDX_W'(1);
                    len_next = len_reg + PLEN_W'(1);
                end
                else if (j_reg == '0)
                begin
                    i_next = i_reg - IDX_W'(1);
                    len_next = len_reg + PLEN_W'(1);
                end
                else
                begin
                    cm_raddr = cm_at(i_reg - IDX_W'(1), j_reg);
                    state_next = ST_B_RD1;
                end
            end
            ST_B_RD1:
            begin
                cm_raddr = cm_at(i_reg, j_reg - IDX_W'(1));
                up_next  = cm_rdata;
                state_next = ST_B_RD2;
            end
            ST_B_RD2:
            begin
                cm_raddr  = cm_at(i_reg - IDX_W'(1), j_reg - IDX_W'(1));
                left_next = cm_rdata;
                state_next = ST_B_WAIT3;
            end
            ST_B_WAIT3:
            begin
                // tie order: up, then left, then diagonal
                if (up_reg == m3)
                    i_next = i_reg - IDX_W'(1);
                else if (left_reg == m3)
                    j_next = j_reg - IDX_W'(1);
                else
                begin
                    i_next = i_reg - IDX_W'(1);
                    j_next = j_reg - IDX_W'(1);
                end
                len_next = len_reg + PLEN_W'(1);
                state_next = ST_B_STEP;
            end
            ST_MUL1:
            begin
                sq_next = (2*PLEN_W)'(len_reg) * (2*PLEN_W)'(len_reg);
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                den_next = (DIM_W+2*PLEN_W)'(dims_reg) * (DIM_W+2*PLEN_W)'(sq_reg);
                q_next   = cost_reg;
                rem_next = '0;
                cnt_next = 6'(COST_W);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                q_next = {q_reg[COST_W-2:0], 1'b0};
                if (div_rem >= (COST_W+1)'(den_reg))
                begin
                    rem_next  = COST_W'(div_rem - (COST_W+1)'(den_reg));
                    q_next[0] = 1'b1;
                end
                else
                    rem_next = div_rem[COST_W-1:0];
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    sv_next   = '0;
                    root_next = '0;
                    cnt_next  = 6'(COST_W/2);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                // digit-by-digit root: two radicand bits per cycle
                sv_next   = {sv_reg[COST_W-3:0], q_reg[COST_W-1:COST_W-2]};
                q_next    = {q_reg[COST_W-3:0], 2'b00};
                root_next = {root_reg[COST_W-2:0], 1'b0};
                if ({3'b0, sv_next} >= {1'b0, root_reg, 2'b01})
                begin
                    sv_next   = sv_next - {root_reg[COST_W-3:0], 2'b01};
                    root_next = {root_reg[COST_W-2:0], 1'b1};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                dist_next  = (|root_reg[COST_W-1:32]) ? 32'hFFFF_FFFF : root_reg[31:0];
                done_next  = 1'b1;
                state_next = ST_B_WAITC;
            end
            ST_B_WAITC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the DTW path-normalised distance core.
`timescale 1ns / 1ps

module testbench;
    import dtw_pkg::*;

    // Sample patterns used when building a sequence
    typedef enum int {
        PAT_RANDOM,
        PAT_NEAR,
        PAT_EQUAL,
        PAT_A_MAX,
        PAT_B_MAX,
        PAT_RAILS
    } sample_pat_t;

    // One directed row: raw register values, pattern, pair count offset
    // from the well-formed count, and an optional typed-in expectation.
    typedef struct {
        int          seq_raw;
        int          dims_raw;
        sample_pat_t pat;
        int          extra;
        bit          typed;
        logic [31:0] exp_dist;
        logic [6:0]  plen;
    } seq_case_t;

    localparam longint unsigned COST_SAT = (64'd1 << 48) - 64'd1;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    dtw_in_t          in_item;
    logic             done;
    dtw_out_t         result;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    // Predictor state
    logic [15:0]     mirror_a [STORE_DEPTH];
    logic [15:0]     mirror_b [STORE_DEPTH];
    longint unsigned warp_cost [CM_DEPTH];
    int              load_pos;
    int              fill_mark;    // store entries written so far, from 0
    logic [6:0]      seq_reg;
    logic [3:0]      dims_reg;

    dtw_out_t        expected_distances [$];
    int              err_count;
    int              result_count;
    int              item_count;
    int              burst_left;
    int              big_runs;

    dtw_path_normalized_distance_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_item   (in_item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    task automatic report(input string msg);
        begin
            err_count++;
            if (err_count <= 40)
                $display("MISMATCH @%0t: %s", $realtime, msg);
        end
    endtask

    function automatic longint unsigned sat_sum(input longint unsigned x,
                                                input longint unsigned y);
        longint unsigned s;
        begin
            s = x + y;
            if (s > COST_SAT || s < x)
                s = COST_SAT;
            return s;
        end
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        begin
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        end
    endfunction

    function automatic int eff_len(input int raw);
        begin
            return (raw < 1) ? 1 : (raw > MAX_LEN) ? MAX_LEN : raw;
        end
    endfunction

    function automatic int eff_dims(input int raw);
        begin
            return (raw < 1) ? 1 : (raw > MAX_DIMS) ? MAX_DIMS : raw;
        end
    endfunction

    // Full matrix fill, then backtrack from the far corner: up wins ties,
    // then left, then diagonal; edges walk straight along.
    function automatic dtw_out_t warp_distance();
        int              n, d, i, j, k, len;
        longint signed   diff;
        longint unsigned c, prev, up, lf, dg, m, total, q, r;
        dtw_out_t        res;
        begin
            n = eff_len(seq_reg);
            d = eff_dims(dims_reg);
            for (i = 0; i < n; i++)
            begin
                for (j = 0; j < n; j++)
                begin
                    c = 0;
                    for (k = 0; k < d; k++)
                    begin
                        diff = longint'(mirror_a[(k * n + i) % STORE_DEPTH])
                             - longint'(mirror_b[(k * n + j) % STORE_DEPTH]);
                        if (diff < 0)
                            diff = -diff;
                        c = sat_sum(c, longint'(diff) * longint'(diff));
                    end
                    if (i == 0 && j == 0)
                        prev = 0;
                    else if (i == 0)
                        prev = warp_cost[j - 1];
                    else if (j == 0)
                        prev = warp_cost[(i - 1) * MAX_LEN];
                    else
                    begin
                        prev = warp_cost[(i - 1) * MAX_LEN + j];
                        if (warp_cost[i * MAX_LEN + j - 1] < prev)
                            prev = warp_cost[i * MAX_LEN + j - 1];
                        if (warp_cost[(i - 1) * MAX_LEN + j - 1] < prev)
                            prev = warp_cost[(i - 1) * MAX_LEN + j - 1];
                    end
                    warp_cost[i * MAX_LEN + j] = sat_sum(c, prev);
                end
            end
            total = warp_cost[(n - 1) * MAX_LEN + n - 1];
            i = n - 1;
            j = n - 1;
            len = 1;
            while (i > 0 || j > 0)
            begin
                if (i == 0)
                    j--;
                else if (j == 0)
                    i--;
                else
                begin
                    up = warp_cost[(i - 1) * MAX_LEN + j];
                    lf = warp_cost[i * MAX_LEN + j - 1];
                    dg = warp_cost[(i - 1) * MAX_LEN + j - 1];
                    m = up;
                    if (lf < m)
                        m = lf;
                    if (dg < m)
                        m = dg;
                    if (up == m)
                        i--;
                    else if (lf == m)
                        j--;
                    else
                    begin
                        i--;
                        j--;
                    end
                end
                len++;
            end
            q = total / (longint'(d) * len * len);
            r = int_sqrt(q);
            res.distance    = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
            res.path_length = len[6:0];
            return res;
        end
    endfunction

    // Store the pair; a flagged pair yields one expected result
    function automatic bit predict_distance(input dtw_in_t it, output dtw_out_t res);
        begin
            mirror_a[load_pos] = it.sample_a;
            mirror_b[load_pos] = it.sample_b;
            if (load_pos >= fill_mark)
                fill_mark = load_pos + 1;
            load_pos = (load_pos + 1) % STORE_DEPTH;
            if (!it.last_pair)
                return 1'b0;
            load_pos = 0;
            res = warp_distance();
            return 1'b1;
        end
    endfunction

    // Drive one item in bursts; returns once it is accepted
    task automatic push_item(input dtw_in_t it, input bit typed, input dtw_out_t want);
        int       gap;
        bit       taken;
        dtw_out_t res;
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                burst_left = $urandom_range(1, 24);
                if (gap > 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            start   <= 1'b1;
            in_item <= it;
            do
            begin
                @(negedge clk);
                taken = !busy;
                @(posedge clk);
            end
            while (!taken);
            burst_left--;
            item_count++;
            if (predict_distance(it, res))
                expected_distances.push_back(typed ? want : res);
        end
    endtask

    function automatic dtw_in_t make_pair(input sample_pat_t pat, input bit last);
        dtw_in_t it;
        begin
            it.sample_a  = 16'($urandom);
            it.sample_b  = 16'($urandom);
            it.last_pair = last;
            case (pat)
                PAT_NEAR:  it.sample_b = it.sample_a + 16'($urandom_range(0, 15));
                PAT_EQUAL: it.sample_b = it.sample_a;
                PAT_A_MAX:
                begin
                    it.sample_a = 16'hFFFF;
                    it.sample_b = 16'h0000;
                end
                PAT_B_MAX:
                begin
                    it.sample_a = 16'h0000;
                    it.sample_b = 16'hFFFF;
                end
                PAT_RAILS:
                begin
                    it.sample_a = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    it.sample_b = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                end
                default: ;
            endcase
            return it;
        end
    endfunction

    // Send a sequence of count pairs, the final one flagged
    task automatic push_sequence(input sample_pat_t pat, input int count,
                                 input bit typed, input dtw_out_t want);
        int p;
        begin
            for (p = 0; p < count; p++)
                push_item(make_pair(pat, p == count - 1), typed, want);
        end
    endtask

    // Wait until every result is in and the core has gone quiet
    task automatic drain();
        begin
            start <= 1'b0;
            @(posedge clk);
            while (expected_distances.size() != 0 || busy)
                @(posedge clk);
            repeat (16) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic idx, input int value);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value[CFG_W-1:0];
            @(posedge clk);
            cfg_we <= 1'b0;
            if (idx == CFG_SEQ_LENGTH)
                seq_reg = value[6:0];
            else
                dims_reg = value[3:0];
        end
    endtask

    // Results are sampled mid-cycle, away from the driving edge
    always @(negedge clk)
    begin
        dtw_out_t want;
        if (rst_n && done)
        begin
            result_count++;
            if (expected_distances.size() == 0)
                report($sformatf("unexpected result dist=%h len=%0d",
                                 result.distance, result.path_length));
            else
            begin
                want = expected_distances.pop_front();
                if (result.distance !== want.distance)
                    report($sformatf("distance %h, expected %h",
                                     result.distance, want.distance));
                if (result.path_length !== want.path_length)
                    report($sformatf("path_length %0d, expected %0d",
                                     result.path_length, want.path_length));
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("Timeout: %0d results still pending", expected_distances.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        seq_case_t       dir_tab [10];
        dtw_out_t        want;
        int              r, n, d, count, rand_items;
        sample_pat_t     pat;

        dir_tab[0] = '{1, 1, PAT_EQUAL, 0, 1'b1, 32'd0, 7'd1};
        dir_tab[1] = '{1, 1, PAT_A_MAX, 0, 1'b1, 32'd65535, 7'd1};
        dir_tab[2] = '{1, 1, PAT_B_MAX, 0, 1'b1, 32'd65535, 7'd1};
        // matched sequences: zero cost along the diagonal
        dir_tab[3] = '{4, 1, PAT_EQUAL, 0, 1'b0, 32'd0, 7'd0};
        // zero registers act as one
        dir_tab[4] = '{0, 0, PAT_A_MAX, 0, 1'b1, 32'd65535, 7'd1};
        dir_tab[5] = '{4, 3, PAT_RANDOM, 0, 1'b0, 32'd0, 7'd0};
        dir_tab[6] = '{2, 2, PAT_RANDOM, -3, 1'b0, 32'd0, 7'd0};
        dir_tab[7] = '{3, 2, PAT_RAILS, 2, 1'b0, 32'd0, 7'd0};
        // registers above range clamp to the maximum sizes
        dir_tab[8] = '{127, 1, PAT_A_MAX, 0, 1'b0, 32'd0, 7'd0};
        dir_tab[9] = '{2, 15, PAT_NEAR, 0, 1'b0, 32'd0, 7'd0};

        rst_n      = 1'b0;
        start      = 1'b0;
        in_item    = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_SEQ_LENGTH;
        cfg_data   = '0;
        seq_reg    = 7'd64;
        dims_reg   = 4'd1;
        load_pos   = 0;
        fill_mark  = 0;
        err_count  = 0;
        result_count = 0;
        item_count = 0;
        burst_left = 0;
        big_runs   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < 10; r++)
        begin
            write_reg(CFG_SEQ_LENGTH, dir_tab[r].seq_raw);
            write_reg(CFG_NUM_DIMS, dir_tab[r].dims_raw);
            want.distance    = dir_tab[r].exp_dist;
            want.path_length = dir_tab[r].plen;
            count = eff_len(seq_reg) * eff_dims(dims_reg) + dir_tab[r].extra;
            push_sequence(dir_tab[r].pat, count, dir_tab[r].typed, want);
            drain();
        end

        // Random sequences: mostly small and well formed, a few large,
        // some with the wrong pair count where the store already holds data.
        rand_items = 0;
        while (rand_items < 490)
        begin
            if (big_runs < 2 && $urandom_range(0, 19) == 0)
            begin
                n = $urandom_range(33, 64);
                d = $urandom_range(1, 2);
                big_runs++;
            end
            else
            begin
                n = $urandom_range(1, 8);
                d = (n <= 4) ? $urandom_range(1, 8) : $urandom_range(1, 4);
            end
            if (n != eff_len(seq_reg) || $urandom_range(0, 3) == 0)
                write_reg(CFG_SEQ_LENGTH, (n == 1 && $urandom_range(0, 1)) ? 0 : n);
            if (d != eff_dims(dims_reg) || $urandom_range(0, 3) == 0)
                write_reg(CFG_NUM_DIMS, (d == MAX_DIMS && $urandom_range(0, 1)) ? 15 : d);
            pat = sample_pat_t'($urandom_range(0, 9) < 5 ? PAT_RANDOM
                                                          : $urandom_range(0, 5));
            count = n * d;
            if ($urandom_range(0, 6) == 0 && n * d <= fill_mark)
                count = $urandom_range(1, n * d + 4);
            push_sequence(pat, count, 1'b0, want);
            rand_items += count;
            drain();
        end

        $display("Covered %0d items and %0d distance results over many sizes,",
                 item_count, result_count);
        $display("including clamped registers and miscounted sequences.");
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
sv/dtw_pkg.sv
sv/dtw_ram.sv
sv/dtw_path_normalized_distance_core.sv
tb/testbench.sv
